@@ rtl/ral_pkg.sv @@
// Shared types and constants for the ranked array list.
package ral_pkg;

    localparam int OPCODE_W   = 3;
    localparam int RANK_W     = 7;
    localparam int VALUE_W    = 32;
    localparam int ITEM_OUT_W = 32;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QFILL_W = $clog2(QDEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET       = 3'd0,
        OP_SET       = 3'd1,
        OP_INS_RANK  = 3'd2,
        OP_INS_FIRST = 3'd3,
        OP_INS_LAST  = 3'd4,
        OP_RM_RANK   = 3'd5,
        OP_RM_FIRST  = 3'd6,
        OP_RM_LAST   = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RANK = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Operation class and where it acts, as decoded by the front end.
    typedef enum logic [1:0] {
        K_READ   = 2'd0,
        K_WRITE  = 2'd1,
        K_INSERT = 2'd2,
        K_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        W_RANK  = 2'd0,
        W_FIRST = 2'd1,
        W_LAST  = 2'd2
    } where_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [RANK_W-1:0]   rank;
        logic [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [ITEM_OUT_W-1:0] item_out;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic                  is_empty;
    } rsp_t;

    typedef struct packed {
        kind_t              kind;
        where_t             where;
        logic [RANK_W-1:0]  rank;
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

@@ rtl/ranked_array_list_core.sv @@
// Top level of the ranked array list: decode front end, queue and execution back end.
//
// Usage: a list of up to DEPTH items addressed by 1-based rank.
// Request channel (req_valid / req_stall / req): opcode, rank and value. A
// request is taken on a rising edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp): item_out, status, count
// and is_empty; exactly one response per request, in request order.
// The front end decodes each request into a two-entry command queue, so it
// keeps taking requests while the back end is busy or a response waits,
// until the queue is full. The back end runs one command at a time on a
// one-read, one-write entry RAM. Each command goes from idle through its
// own states to done, where the response register loads: get reads the
// entry and captures it, set writes it, insert shifts entries up and then
// writes the new one, remove captures the entry and then shifts entries
// down; an error goes straight to done. Shifting moves one entry per cycle:
// each cycle reads the next entry and writes the one read the cycle before.
// A queued request starts the cycle after the previous response loads.
// Reset clears the count and all handshake state; the list starts empty.
// The RAM needs no clearing pass: only entries below the count are read.
// A stalled response holds in its register; the back end finishes the next
// command and then waits until that register frees up.
module ranked_array_list_core
    import ral_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // request decode and queue
    ral_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // checks, entry shifting and response register
    ral_back #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ rtl/ral_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ral_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ral_front.sv @@
// Front end: accepts requests, decodes the opcode and queues commands.
module ral_front
    import ral_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic cmd_valid,
    input  logic cmd_pop,
    output cmd_t cmd
);

    cmd_t               dec;
    cmd_t               q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               push;

    always_comb
    begin
        dec.rank  = req.rank;
        dec.value = req.value;
        dec.kind  = K_READ;
        dec.where = W_RANK;
        unique case (req.opcode) inside
            OP_GET:
            begin
                dec.kind = K_READ;
            end
            OP_SET:
            begin
                dec.kind = K_WRITE;
            end
            OP_INS_RANK, OP_INS_FIRST, OP_INS_LAST:
            begin
                dec.kind = K_INSERT;
            end
            OP_RM_RANK, OP_RM_FIRST, OP_RM_LAST:
            begin
                dec.kind = K_REMOVE;
            end
            default:
            begin
                dec.kind = K_READ;
            end
        endcase
        unique case (req.opcode) inside
            OP_INS_FIRST, OP_RM_FIRST:
            begin
                dec.where = W_FIRST;
            end
            OP_INS_LAST, OP_RM_LAST:
            begin
                dec.where = W_LAST;
            end
            default:
            begin
                dec.where = W_RANK;
            end
        endcase
    end

    assign req_stall = (fill_reg == QFILL_W'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ rtl/ral_back.sv @@
// Back end: checks each command against the count and runs it on the entry RAM.
module ral_back
    import ral_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((RANK_W > CW) ? RANK_W : CW) + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HEAD  = 7'b0000010,
        S_CAP   = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_INS   = 7'b0010000,
        S_RM    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         pos_reg, pos_next;
    kind_t                 kind_reg, kind_next;
    logic [ITEM_WIDTH-1:0] value_reg, value_next;
    status_t               status_reg, status_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic                  w_pend_reg, w_pend_next;
    logic [AW-1:0]         w_addr_reg, w_addr_next;
    logic                  res_valid_reg, res_valid_next;
    rsp_t                  res_reg, res_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [CMPW-1:0]       rank_x, cnt_x, depth_x, rank_m1;
    logic                  rank_ok, ins_ok, full, empty, res_free;
    status_t               err;
    logic [AW-1:0]         pos_sel;

    ral_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Rank, fullness and emptiness checks on the command at the queue head.
    assign rank_x  = CMPW'(cmd.rank);
    assign cnt_x   = CMPW'(count_reg);
    assign depth_x = CMPW'(DEPTH);
    assign rank_m1 = rank_x - CMPW'(1);
    assign rank_ok = (rank_x != '0) && (rank_x <= cnt_x) && (rank_x <= depth_x);
    assign ins_ok  = (rank_x != '0) && (rank_x <= cnt_x + CMPW'(1)) && (rank_x <= depth_x);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        err     = ST_OK;
        pos_sel = AW'(rank_m1);
        unique case (cmd.kind) inside
            K_READ, K_WRITE:
            begin
                if (!rank_ok)
                begin
                    err = ST_BAD_RANK;
                end
            end
            K_INSERT:
            begin
                unique case (cmd.where)
                    W_RANK:
                    begin
                        if (!ins_ok)
                        begin
                            err = ST_BAD_RANK;
                        end
                        else if (full)
                        begin
                            err = ST_FULL;
                        end
                    end
                    W_FIRST:
                    begin
                        pos_sel = '0;
                        if (full)
                        begin
                            err = ST_FULL;
                        end
                    end
                    W_LAST:
                    begin
                        pos_sel = AW'(count_reg);
                        if (full)
                        begin
                            err = ST_FULL;
                        end
                    end
                    default:
                    begin
                        err = ST_BAD_RANK;
                    end
                endcase
            end
            K_REMOVE:
            begin
                unique case (cmd.where)
                    W_RANK:
                    begin
                        if (!rank_ok)
                        begin
                            err = ST_BAD_RANK;
                        end
                    end
                    W_FIRST:
                    begin
                        pos_sel = '0;
                        if (empty)
                        begin
                            err = ST_EMPTY;
                        end
                    end
                    W_LAST:
                    begin
                        pos_sel = AW'(count_reg - CW'(1));
                        if (empty)
                        begin
                            err = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        err = ST_BAD_RANK;
                    end
                endcase
            end
            default:
            begin
                err = ST_BAD_RANK;
            end
        endcase
    end

    assign res_free = !res_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        w_pend_next    = w_pend_reg;
        w_addr_next    = w_addr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = w_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        if (res_valid_reg && !rsp_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    kind_next   = cmd.kind;
                    value_next  = ITEM_WIDTH'(cmd.value);
                    pos_next    = pos_sel;
                    status_next = err;
                    item_next   = '0;
                    w_pend_next = 1'b0;
                    cur_next    = count_reg;
                    if (err != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unique case (cmd.kind)
                            K_READ:   state_next = S_HEAD;
                            K_WRITE:  state_next = S_WRITE;
                            K_INSERT: state_next = S_INS;
                            K_REMOVE: state_next = S_HEAD;
                            default:  state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_HEAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pos_reg;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                item_next  = ram_rdata;
                cur_next   = CW'(pos_reg);
                state_next = (kind_reg == K_REMOVE) ? S_RM : S_DONE;
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = value_reg;
                state_next = S_DONE;
            end
            S_INS:
            begin
                // read entry cur-1, write it to cur on the next cycle
                if (w_pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (cur_reg > CW'(pos_reg))
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = AW'(cur_reg - CW'(1));
                    w_pend_next = 1'b1;
                    w_addr_next = AW'(cur_reg);
                    cur_next    = cur_reg - CW'(1);
                end
                else if (!w_pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    w_pend_next = 1'b0;
                end
            end
            S_RM:
            begin
                // read entry cur+1, write it to cur on the next cycle
                if (w_pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if ((cur_reg + CW'(1)) < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = AW'(cur_reg + CW'(1));
                    w_pend_next = 1'b1;
                    w_addr_next = AW'(cur_reg);
                    cur_next    = cur_reg + CW'(1);
                end
                else if (!w_pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    w_pend_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.item_out = ITEM_OUT_W'(item_reg);
                    res_next.status   = status_reg;
                    res_next.count    = COUNT_W'(count_reg);
                    res_next.is_empty = (count_reg == '0);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            w_pend_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            w_pend_reg    <= w_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        w_addr_reg <= w_addr_next;
        res_reg    <= res_next;
    end

    assign rsp_valid = res_valid_reg;
    assign rsp       = res_reg;

endmodule

@@ tb/tb_ranked_array_list_core.sv @@
// Self-checking testbench for the ranked array list core.
`timescale 1ns / 100ps

module tb_ranked_array_list_core;
    import ral_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int ITEM_BITS    = 32;
    localparam int RANDOM_OPS   = 1440;
    // Worst case per request: an idle gap, a shift across the whole list and
    // a receiver stall. About 1600 requests, taken 7x over.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Longest back end latency plus margin, used for the quiet tail.
    localparam int SETTLE_TICKS = 2 * LIST_DEPTH + 16;
    localparam int MAX_REPORTS  = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the list, advanced once per accepted request.
    logic [ITEM_BITS-1:0] list_items [0:LIST_DEPTH-1];
    int                   list_count = 0;

    // Responses predicted but not yet seen, oldest first.
    rsp_t pending_rsps [$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;  // when set, neither side inserts gaps
    bit  rsp_taken   = 1'b0;  // set at negedge when a response goes at the next edge
    int  rsp_wait    = 0;

    always #4 clk = ~clk;

    ranked_array_list_core #(
        .DEPTH      (LIST_DEPTH),
        .ITEM_WIDTH (ITEM_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------

    // Open a hole at 0-based slot pos, shifting later entries up.
    function automatic void open_slot(input int pos, input logic [ITEM_BITS-1:0] v);
        for (int i = list_count; i > pos; i--)
            list_items[i] = list_items[i-1];
        list_items[pos] = v;
        list_count++;
    endfunction

    // Pull out 0-based slot pos, shifting later entries down.
    function automatic logic [ITEM_BITS-1:0] take_slot(input int pos);
        logic [ITEM_BITS-1:0] v;
        v = list_items[pos];
        for (int i = pos; i + 1 < list_count; i++)
            list_items[i] = list_items[i+1];
        list_count--;
        return v;
    endfunction

    // Apply one request to the shadow list and return the response it must produce.
    function automatic rsp_t apply_list_op(input req_t r);
        rsp_t o;
        int   rk;
        bit   rank_in;
        o       = '0;
        o.status = ST_OK;
        rk      = r.rank;
        rank_in = (rk >= 1) && (rk <= list_count);
        case (opcode_t'(r.opcode))
            OP_GET:
                if (!rank_in) o.status = ST_BAD_RANK;
                else          o.item_out = list_items[rk-1];
            OP_SET:
                if (!rank_in) o.status = ST_BAD_RANK;
                else          list_items[rk-1] = r.value;
            OP_INS_RANK:
                // rank is judged before fullness
                if (rk < 1 || rk > list_count + 1 || rk > LIST_DEPTH)
                    o.status = ST_BAD_RANK;
                else if (list_count >= LIST_DEPTH)
                    o.status = ST_FULL;
                else
                    open_slot(rk - 1, r.value);
            OP_INS_FIRST, OP_INS_LAST:
                if (list_count >= LIST_DEPTH)
                    o.status = ST_FULL;
                else
                    open_slot(opcode_t'(r.opcode) == OP_INS_FIRST ? 0 : list_count, r.value);
            OP_RM_RANK:
                // an empty list fails the rank check, not the empty check
                if (!rank_in) o.status = ST_BAD_RANK;
                else          o.item_out = take_slot(rk - 1);
            default:
                if (list_count == 0)
                    o.status = ST_EMPTY;
                else
                    o.item_out = take_slot(opcode_t'(r.opcode) == OP_RM_FIRST ?
                                           0 : list_count - 1);
        endcase
        o.count    = COUNT_W'(list_count);
        o.is_empty = (list_count == 0);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one request, hold it through stalls, predict on acceptance.
    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic send_request(input req_t r);
        int gap;
        bit stalled;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        // stall is sampled mid-cycle, where it is settled
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end while (stalled);
        pending_rsps.push_back(apply_list_op(r));
    endtask

    task automatic send_op(input opcode_t op, input int rank, input logic [31:0] value);
        req_t r;
        r.opcode = op;
        r.rank   = RANK_W'(rank);
        r.value  = value;
        send_request(r);
    endtask

    // Stop sending until every predicted response has come back.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Well-formed op with random content; a few are plain noise.
    // grow tilts the mix toward inserts so the list fills up.
    function automatic req_t random_list_op(input bit grow);
        req_t r;
        int   pick;
        int   top;
        r.value = $urandom;
        r.rank  = RANK_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 8)
        begin
            r.opcode = OPCODE_W'($urandom_range(0, 7));
            return r;
        end
        pick = $urandom_range(0, 99);
        if (pick < (grow ? 55 : 20))
        begin
            case ($urandom_range(0, 2))
                0:       r.opcode = OP_INS_RANK;
                1:       r.opcode = OP_INS_FIRST;
                default: r.opcode = OP_INS_LAST;
            endcase
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 2))
                0:       r.opcode = OP_RM_RANK;
                1:       r.opcode = OP_RM_FIRST;
                default: r.opcode = OP_RM_LAST;
            endcase
        end
        else
            r.opcode = $urandom_range(0, 1) ? OP_GET : OP_SET;

        // ranked ops mostly aim inside the list
        if (opcode_t'(r.opcode) == OP_INS_RANK)
        begin
            top    = (list_count < LIST_DEPTH) ? list_count + 1 : LIST_DEPTH;
            r.rank = RANK_W'($urandom_range(1, top));
        end
        else if (opcode_t'(r.opcode) inside {OP_GET, OP_SET, OP_RM_RANK})
        begin
            top    = (list_count > 0) ? list_count : 1;
            r.rank = RANK_W'($urandom_range(1, top));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected item=%h status=%0d count=%0d empty=%0b, got item=%h status=%0d count=%0d empty=%0b",
                     $realtime, what, want.item_out, want.status, want.count, want.is_empty,
                     got.item_out, got.status, got.count, got.is_empty);
    endtask

    // Outputs and stall are settled at the falling edge; a response valid
    // and unstalled here is taken at the next rising edge.
    always @(negedge clk)
    begin
        rsp_t want;
        bit   bad;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            rsp_taken = 1'b1;
            if (pending_rsps.size() == 0)
                note_failure("response with no request outstanding", '0, rsp);
            else
            begin
                want = pending_rsps.pop_front();
                bad  = (rsp.item_out !== want.item_out) || (rsp.status !== want.status) ||
                       (rsp.count !== want.count) || (rsp.is_empty !== want.is_empty);
                if (bad)
                    note_failure("response mismatch", want, rsp);
            end
        end
    end

    // Receiver back-pressure: a fresh wait, drawn at random, follows each response.
    always @(posedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_wait  = no_idle ? 0 : $urandom_range(0, 5);
            rsp_taken = 1'b0;
        end
        if (rsp_wait > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_wait--;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode on a short list, most on an empty one, field extremes, error paths.
    task automatic test_basic_ops();
        send_op(OP_GET,       1,   32'h0000_0001);  // nothing to read
        send_op(OP_RM_RANK,   1,   32'h0);          // empty list: bad rank wins
        send_op(OP_RM_FIRST,  0,   32'h0);          // empty
        send_op(OP_RM_LAST,   127, 32'h0);          // empty
        send_op(OP_INS_RANK,  0,   32'hDEAD_BEEF);  // rank zero
        send_op(OP_INS_RANK,  2,   32'hDEAD_BEEF);  // past count+1
        send_op(OP_INS_RANK,  1,   32'h0000_0000);
        send_op(OP_INS_FIRST, 127, 32'hFFFF_FFFF);
        send_op(OP_INS_LAST,  0,   32'h5A5A_A5A5);
        send_op(OP_INS_RANK,  2,   32'h1234_5678);  // middle insert
        send_op(OP_INS_RANK,  5,   32'h8000_0001);  // exactly count+1
        send_op(OP_GET,       1,   32'h0);
        send_op(OP_GET,       5,   32'h0);
        send_op(OP_GET,       6,   32'h0);          // one past the end
        send_op(OP_GET,       127, 32'h0);
        send_op(OP_SET,       3,   32'hA5A5_5A5A);
        send_op(OP_SET,       0,   32'hFFFF_FFFF);  // rank zero
        send_op(OP_GET,       3,   32'h0);
        send_op(OP_RM_RANK,   3,   32'h0);
        send_op(OP_RM_RANK,   0,   32'h0);
        send_op(OP_RM_FIRST,  0,   32'h0);
        send_op(OP_RM_LAST,   0,   32'h0);
        send_op(OP_RM_RANK,   1,   32'h0);
        send_op(OP_RM_RANK,   1,   32'h0);          // last one out
        send_op(OP_GET,       1,   32'h0);
    endtask

    // Fill to DEPTH, probe the full-list and rank-range errors, drain to empty.
    task automatic test_full_list();
        req_t r;
        while (list_count < LIST_DEPTH)
        begin
            r = random_list_op(1'b1);
            if (opcode_t'(r.opcode) inside {OP_INS_RANK, OP_INS_FIRST, OP_INS_LAST})
                send_request(r);
        end
        send_op(OP_INS_RANK,  LIST_DEPTH + 1, $urandom);  // beyond DEPTH: bad rank
        send_op(OP_INS_RANK,  0,              $urandom);  // bad rank beats full
        send_op(OP_INS_RANK,  LIST_DEPTH,     $urandom);  // full
        send_op(OP_INS_FIRST, 0,              $urandom);  // full
        send_op(OP_INS_LAST,  0,              $urandom);  // full
        send_op(OP_GET,       LIST_DEPTH,     32'h0);
        send_op(OP_SET,       LIST_DEPTH,     $urandom);
        send_op(OP_GET,       LIST_DEPTH + 1, 32'h0);
        while (list_count > 0)
        begin
            r = random_list_op(1'b0);
            if (opcode_t'(r.opcode) inside {OP_RM_RANK, OP_RM_FIRST, OP_RM_LAST})
                send_request(r);
        end
        send_op(OP_RM_FIRST, 0, 32'h0);
    endtask

    // Long mixed traffic in phases that alternately grow and shrink the list.
    task automatic test_random_traffic(input int total);
        int  done;
        int  phase_len;
        bit  grow;
        done = 0;
        grow = 1'b1;
        while (done < total)
        begin
            phase_len = $urandom_range(40, 160);
            no_idle   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && done < total; i++)
            begin
                send_request(random_list_op(grow));
                done++;
            end
            grow = ~grow;
            // now and then let everything drain mid-run
            if ($urandom_range(0, 4) == 0)
                wait_for_responses();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        wait_for_responses();   // sender holds off until the pipe is empty
        test_full_list();
        wait_for_responses();
        test_random_traffic(RANDOM_OPS);

        wait_for_responses();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
